>>> rtl/rcfp_pkg.sv
package rcfp_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 3'd4;

	// Register values after reset.
	localparam logic [7:0]  RST_START_CHAR = 8'd60;    // '<'
	localparam logic [7:0]  RST_END_CHAR   = 8'd62;    // '>'
	localparam logic [15:0] RST_MIN_VALID  = 16'd900;
	localparam logic [15:0] RST_MAX_VALID  = 16'd2100;
	localparam logic [15:0] RST_TIMEOUT_MS = 16'd500;

	// Stream widths, padded to whole bytes.
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;

	// Frame status codes.
	typedef enum logic [1:0] {
		STATUS_NONE     = 2'd0,
		STATUS_ACCEPTED = 2'd1,
		STATUS_REJECTED = 2'd2
	} frame_status_t;

	// One result item as it sits in the output register.
	typedef struct packed {
		frame_status_t frame_status;
		logic          new_frame;
		logic          frame_lost;
		logic          failsafe;
		logic [15:0]   steering;
		logic [15:0]   throttle;
	} result_t;

endpackage

>>> rtl/rc_frame_parser_failsafe_core.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: mode, tdata: data_byte, ack_frame
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: throttle .. frame_status
// cfg       in         cfg_we (no wait, no read-back) cfg_index, cfg_data
//
// Every item yields exactly one result: it first waits in the input register, then the parser
// and timer logic loads the result register.
// One item per cycle is sustained while results are taken; the only loop is the state update.
// Reset (arst_n low) puts the parser back to waiting for a start character, sets failsafe,
// clears the stored channels and the timer, and restores the register defaults.
// When the result register holds a result that is not taken, the input register holds its
// item and s_axis_tready drops only while both are full.
module rc_frame_parser_failsafe_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [7:0] data_byte, [8] ack_frame, [15:9] zero
	input  logic [rcfp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] mode: 0 received byte, 1 millisecond tick
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [15:0] throttle, [31:16] steering, [32] failsafe, [33] frame_lost,
	// [34] new_frame, [36:35] frame_status, [39:37] zero
	output logic [rcfp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [rcfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcfp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rcfp_pkg::*;

	// Parser position within the six-byte frame.
	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_THR_HI = 3'd1,
		PH_THR_LO = 3'd2,
		PH_STE_HI = 3'd3,
		PH_STE_LO = 3'd4,
		PH_END    = 3'd5
	} phase_t;

	// Configuration registers.
	logic [7:0]  start_char_q;
	logic [7:0]  end_char_q;
	logic [15:0] min_valid_q;
	logic [15:0] max_valid_q;
	logic [15:0] timeout_ms_q;

	// Input register.
	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  byte_s1;
	logic        ack_s1;

	// Block state.
	phase_t      phase_q;
	logic [7:0]  byte_q [4];
	logic [15:0] throttle_q;
	logic [15:0] steering_q;
	logic        failsafe_q;
	logic        lost_q;
	logic        fresh_q;
	logic [15:0] elapsed_q;

	// Result register.
	logic        out_valid_q;
	result_t     result_q;

	// Next-state values.
	phase_t        phase_d;
	logic [15:0]   throttle_d;
	logic [15:0]   steering_d;
	logic          failsafe_d;
	logic          lost_d;
	logic          fresh_d;
	logic [15:0]   elapsed_d;
	frame_status_t status_d;
	logic [15:0]   frame_thr;
	logic [15:0]   frame_ste;
	logic          in_range;

	logic advance;

	// The item in the input register moves on when the result register is free or being
	// emptied in this cycle; the input register then takes a new transfer at once.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign frame_thr = {byte_q[0], byte_q[1]};
	assign frame_ste = {byte_q[2], byte_q[3]};
	assign in_range  = (frame_thr >= min_valid_q) && (frame_thr <= max_valid_q) &&
	                   (frame_ste >= min_valid_q) && (frame_ste <= max_valid_q);

	always_comb begin
		phase_d    = phase_q;
		throttle_d = throttle_q;
		steering_d = steering_q;
		failsafe_d = failsafe_q;
		lost_d     = lost_q;
		fresh_d    = ack_s1 ? 1'b0 : fresh_q;
		elapsed_d  = elapsed_q;
		status_d   = STATUS_NONE;
		if (mode_s1) begin
			// Tick: saturating count, then compare against the timeout.
			if (elapsed_q != 16'hFFFF) begin
				elapsed_d = elapsed_q + 16'd1;
			end
			if (elapsed_d > timeout_ms_q) begin
				failsafe_d = 1'b1;
				lost_d     = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_THR_HI: phase_d = PH_THR_LO;
				PH_THR_LO: phase_d = PH_STE_HI;
				PH_STE_HI: phase_d = PH_STE_LO;
				PH_STE_LO: phase_d = PH_END;
				PH_END: begin
					// A wrong closing byte drops the frame without a status.
					phase_d = PH_START;
					if (byte_s1 == end_char_q) begin
						if (in_range) begin
							status_d   = STATUS_ACCEPTED;
							throttle_d = frame_thr;
							steering_d = frame_ste;
							failsafe_d = 1'b0;
							lost_d     = 1'b0;
							fresh_d    = 1'b1;
							elapsed_d  = 16'd0;
						end else begin
							status_d = STATUS_REJECTED;
						end
					end
				end
				default: phase_d = (byte_s1 == start_char_q) ? PH_THR_HI : PH_START;
			endcase
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= RST_START_CHAR;
			end_char_q   <= RST_END_CHAR;
			min_valid_q  <= RST_MIN_VALID;
			max_valid_q  <= RST_MAX_VALID;
			timeout_ms_q <= RST_TIMEOUT_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_CHAR: start_char_q <= cfg_data[7:0];
				REG_END_CHAR:   end_char_q   <= cfg_data[7:0];
				REG_MIN_VALID:  min_valid_q  <= cfg_data;
				REG_MAX_VALID:  max_valid_q  <= cfg_data;
				REG_TIMEOUT_MS: timeout_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata[7:0];
			ack_s1  <= s_axis_tdata[8];
		end
	end

	// Data bytes of the frame; written before any read, so they need no reset.
	always_ff @(posedge clk) begin
		if (advance && !mode_s1) begin
			case (phase_q)
				PH_THR_HI: byte_q[0] <= byte_s1;
				PH_THR_LO: byte_q[1] <= byte_s1;
				PH_STE_HI: byte_q[2] <= byte_s1;
				PH_STE_LO: byte_q[3] <= byte_s1;
				default: ;
			endcase
		end
	end

	// Parser state, channel values, flags and the result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			throttle_q  <= 16'd0;
			steering_q  <= 16'd0;
			failsafe_q  <= 1'b1;
			lost_q      <= 1'b0;
			fresh_q     <= 1'b0;
			elapsed_q   <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q    <= phase_d;
				throttle_q <= throttle_d;
				steering_q <= steering_d;
				failsafe_q <= failsafe_d;
				lost_q     <= lost_d;
				fresh_q    <= fresh_d;
				elapsed_q  <= elapsed_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; it is only looked at while out_valid_q is set.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.throttle     <= throttle_d;
			result_q.steering     <= steering_d;
			result_q.failsafe     <= failsafe_d;
			result_q.frame_lost   <= lost_d;
			result_q.new_frame    <= fresh_d;
			result_q.frame_status <= status_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, result_q};

	// Frame-lost is only ever set together with failsafe, and failsafe is only cleared together with it.
	a_lost_implies_failsafe: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && result_q.frame_lost |-> result_q.failsafe)
		else $error("frame_lost reported without failsafe");

	// An accepted frame always leaves failsafe clear and the new-frame flag set.
	a_accept_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (result_q.frame_status == STATUS_ACCEPTED) |->
		result_q.new_frame && !result_q.failsafe)
		else $error("accepted frame with inconsistent flags");

	// A tick never moves the parser.
	a_tick_keeps_phase: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 |=> $stable(phase_q))
		else $error("parser phase changed on a tick");

	// The input side stalls only while both registers are full and the output is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without a full pipeline");

endmodule

>>> test/rc_link_checker.sv
`timescale 1ns / 1ps

module rc_link_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	// [7:0] data_byte, [8] ack_frame, [15:9] zero
	input  logic [rcfp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] mode: 0 received byte, 1 millisecond tick
	input  logic                            s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [15:0] throttle, [31:16] steering, [32] failsafe, [33] frame_lost,
	// [34] new_frame, [36:35] frame_status, [39:37] zero
	input  logic [rcfp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [rcfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcfp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatch_n,
	output int                              pending_n,
	output int                              checked_n,
	output int                              accepted_n,
	output int                              rejected_n
);
	import rcfp_pkg::*;

	localparam logic [2:0] PH_WAIT_START = 3'd0;
	localparam logic [2:0] PH_WAIT_END   = 3'd5;

	// Register copies.
	logic [7:0]  start_ch;
	logic [7:0]  end_ch;
	logic [15:0] lo_lim;
	logic [15:0] hi_lim;
	logic [15:0] timeout_lim;

	// Link state.
	logic [2:0]  parse_ph;
	logic [7:0]  payload [4];
	logic [15:0] thr_q;
	logic [15:0] ste_q;
	logic [15:0] elapsed_q;
	logic        failsafe_q;
	logic        lost_q;
	logic        fresh_q;

	result_t     telemetry_q [$];

	// Advances the link state by one item and returns the telemetry it leaves behind.
	function automatic result_t predict_telemetry(input logic tick, input logic [7:0] rx,
			input logic ack);
		result_t       r;
		logic [15:0]   thr;
		logic [15:0]   ste;
		frame_status_t st;
		st = STATUS_NONE;
		if (ack)
			fresh_q = 1'b0;
		if (tick) begin
			if (elapsed_q != 16'hFFFF)
				elapsed_q = elapsed_q + 16'd1;
			if (elapsed_q > timeout_lim) begin
				failsafe_q = 1'b1;
				lost_q     = 1'b1;
			end
		end else if (parse_ph >= 3'd1 && parse_ph <= 3'd4) begin
			payload[2'(parse_ph - 3'd1)] = rx;
			parse_ph = parse_ph + 3'd1;
		end else if (parse_ph == PH_WAIT_END) begin
			if (rx == end_ch) begin
				thr = {payload[0], payload[1]};
				ste = {payload[2], payload[3]};
				if (thr >= lo_lim && thr <= hi_lim && ste >= lo_lim && ste <= hi_lim) begin
					thr_q      = thr;
					ste_q      = ste;
					failsafe_q = 1'b0;
					lost_q     = 1'b0;
					fresh_q    = 1'b1;
					elapsed_q  = '0;
					st         = STATUS_ACCEPTED;
				end else begin
					st = STATUS_REJECTED;
				end
			end
			parse_ph = PH_WAIT_START;
		end else begin
			parse_ph = (rx == start_ch) ? 3'd1 : PH_WAIT_START;
		end
		r.throttle     = thr_q;
		r.steering     = ste_q;
		r.failsafe     = failsafe_q;
		r.frame_lost   = lost_q;
		r.new_frame    = fresh_q;
		r.frame_status = st;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			start_ch    = RST_START_CHAR;
			end_ch      = RST_END_CHAR;
			lo_lim      = RST_MIN_VALID;
			hi_lim      = RST_MAX_VALID;
			timeout_lim = RST_TIMEOUT_MS;
			parse_ph    = PH_WAIT_START;
			foreach (payload[k])
				payload[k] = '0;
			thr_q       = '0;
			ste_q       = '0;
			elapsed_q   = '0;
			failsafe_q  = 1'b1;
			lost_q      = 1'b0;
			fresh_q     = 1'b0;
			telemetry_q.delete();
			pending_n <= 0;
		end else begin
			// The user must make register writes only while the link is idle; the checker does not enforce it.
			if (cfg_we) begin
				case (cfg_index)
					REG_START_CHAR: start_ch    = cfg_data[7:0];
					REG_END_CHAR:   end_ch      = cfg_data[7:0];
					REG_MIN_VALID:  lo_lim      = cfg_data;
					REG_MAX_VALID:  hi_lim      = cfg_data;
					REG_TIMEOUT_MS: timeout_lim = cfg_data;
					default: ;
				endcase
			end
			// Results come out only after their item has passed the input and result registers, so compare before queueing.
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[$bits(result_t)-1:0];
				if (telemetry_q.size() == 0) begin
					mismatch_n++;
					if (mismatch_n <= 10)
						$display("Unexpected result %h with nothing outstanding", m_axis_tdata);
				end else begin
					want = telemetry_q.pop_front();
					checked_n++;
					if (got.throttle !== want.throttle || got.steering !== want.steering ||
							got.failsafe !== want.failsafe || got.frame_lost !== want.frame_lost ||
							got.new_frame !== want.new_frame ||
							got.frame_status !== want.frame_status ||
							m_axis_tdata[OUT_DATA_W-1:$bits(result_t)] !== '0) begin
						mismatch_n++;
						if (mismatch_n <= 10)
							$display({"Result %0d mismatch: expected thr %0d ste %0d fs %0b lost %0b ",
								"new %0b status %0d, got thr %0d ste %0d fs %0b lost %0b new %0b ",
								"status %0d pad %0h"}, checked_n,
								want.throttle, want.steering, want.failsafe, want.frame_lost,
								want.new_frame, want.frame_status,
								got.throttle, got.steering, got.failsafe, got.frame_lost,
								got.new_frame, got.frame_status,
								m_axis_tdata[OUT_DATA_W-1:$bits(result_t)]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = predict_telemetry(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
				if (want.frame_status == STATUS_ACCEPTED)
					accepted_n++;
				else if (want.frame_status == STATUS_REJECTED)
					rejected_n++;
				telemetry_q.push_back(want);
			end
			pending_n <= telemetry_q.size();
		end
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rcfp_pkg::*;

	// Clock, reset and the block's ports. Every input starts at a known value.
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [7:0] data_byte, [8] ack_frame, [15:9] zero
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	// [0] mode: 0 received byte, 1 millisecond tick
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [15:0] throttle, [31:16] steering, [32] failsafe, [33] frame_lost,
	// [34] new_frame, [36:35] frame_status, [39:37] zero
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	// Figures handed up by the checker.
	int mismatch_n;
	int pending_n;
	int checked_n;
	int accepted_n;
	int rejected_n;

	// The register values currently programmed, so that stimulus can aim at the
	// start and end characters and at the edges of the valid window.
	logic [7:0]  cur_start   = RST_START_CHAR;
	logic [7:0]  cur_end     = RST_END_CHAR;
	logic [15:0] cur_lo      = RST_MIN_VALID;
	logic [15:0] cur_hi      = RST_MAX_VALID;
	logic [15:0] cur_timeout = RST_TIMEOUT_MS;

	// Traffic shaping knobs, all in percent.
	int idle_pct     = 0;
	int stall_pct    = 0;
	int ack_pct      = 0;
	int tick_mix_pct = 0;

	int items_sent   = 0;
	int settings_n   = 1;

	rc_frame_parser_failsafe_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	rc_link_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatch_n    (mismatch_n),
		.pending_n     (pending_n),
		.checked_n     (checked_n),
		.accepted_n    (accepted_n),
		.rejected_n    (rejected_n)
	);

	// 2 ns clock period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver stalls at random, at the rate the current traffic mix asks for.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic roll_ack();
		return $urandom_range(0, 99) < ack_pct;
	endfunction

	// Channel values cluster on the window edges and just outside them, so that
	// both bounds are hit from each side; the rest is inside or anywhere.
	function automatic logic [15:0] pick_channel();
		case ($urandom_range(0, 9))
			0:       return cur_lo;
			1:       return cur_hi;
			2:       return cur_lo - 16'd1;
			3:       return cur_hi + 16'd1;
			4, 5:    return 16'($urandom);
			default: return 16'($urandom_range(cur_lo, cur_hi));
		endcase
	endfunction

	// Offers one item and returns at the edge where the transfer takes place.
	// Idle cycles before the item lower tvalid, each at its own edge, so tvalid
	// stays high without a glitch between back-to-back transfers.
	task automatic push_item(input logic tick, input logic [7:0] rx, input logic ack);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= tick;
		s_axis_tdata  <= {{(IN_DATA_W-9){1'b0}}, ack, rx};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Sends a whole six-byte frame; ticks may slip in before any of its bytes, which the
	// parser must ignore.
	task automatic send_frame(input logic [15:0] thr, input logic [15:0] ste,
			input logic [7:0] end_b);
		logic [7:0] frame_bytes [6];
		frame_bytes = '{cur_start, thr[15:8], thr[7:0], ste[15:8], ste[7:0], end_b};
		foreach (frame_bytes[k]) begin
			if ($urandom_range(0, 99) < tick_mix_pct)
				push_item(1'b1, 8'($urandom), roll_ack());
			push_item(1'b0, frame_bytes[k], roll_ack());
		end
	endtask

	// Stops offering items and waits for every outstanding result, with a limit.
	task automatic drain_link();
		int guard;
		s_axis_tvalid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending_n != 0 && guard < 5000);
		repeat (4) @(posedge clk);
	endtask

	// Writes all five registers while the link is idle.
	task automatic program_link(input logic [7:0] st, input logic [7:0] en,
			input logic [15:0] lo, input logic [15:0] hi, input logic [15:0] tmo);
		logic [CFG_DATA_W-1:0] vals [5];
		logic [CFG_IDX_W-1:0]  idx [5];
		drain_link();
		vals = '{16'(st), 16'(en), lo, hi, tmo};
		idx  = '{REG_START_CHAR, REG_END_CHAR, REG_MIN_VALID, REG_MAX_VALID, REG_TIMEOUT_MS};
		foreach (vals[k]) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= vals[k];
			@(posedge clk);
		end
		cfg_we      <= 1'b0;
		cur_start   = st;
		cur_end     = en;
		cur_lo      = lo;
		cur_hi      = hi;
		cur_timeout = tmo;
		settings_n++;
	endtask

	// Random traffic: mostly well-formed frames with random content, then bursts
	// of ticks long enough to trip a short timeout, stray bytes, and frames that
	// break off early. The idle pattern and the ack rate change every few dozen
	// transfers so that gaps land on every phase of the parser.
	task automatic run_traffic(input int n);
		int stop_at;
		int next_mix;
		int roll;
		int burst;
		stop_at  = items_sent + n;
		next_mix = items_sent;
		while (items_sent < stop_at) begin
			if (items_sent >= next_mix) begin
				case ($urandom_range(0, 3))
					0:       begin idle_pct = 0;  stall_pct = 0;  end
					1:       begin idle_pct = 87; stall_pct = 0;  end
					2:       begin idle_pct = 0;  stall_pct = 87; end
					default: begin idle_pct = 36; stall_pct = 36; end
				endcase
				ack_pct      = $urandom_range(0, 40);
				tick_mix_pct = $urandom_range(0, 25);
				next_mix     = items_sent + $urandom_range(20, 80);
			end
			roll = $urandom_range(0, 19);
			if (roll < 13) begin
				send_frame(pick_channel(), pick_channel(),
					($urandom_range(0, 99) < 85) ? cur_end : 8'($urandom));
			end else if (roll < 15) begin
				if (cur_timeout < 40)
					burst = $urandom_range(1, cur_timeout + 3);
				else
					burst = $urandom_range(1, 6);
				repeat (burst) push_item(1'b1, 8'($urandom), roll_ack());
			end else if (roll < 17) begin
				push_item(1'b0, 8'($urandom), roll_ack());
			end else begin
				// A frame that stops short; whatever follows lands in its slots.
				push_item(1'b0, cur_start, roll_ack());
				repeat ($urandom_range(0, 4)) push_item(1'b0, 8'($urandom), roll_ack());
			end
		end
	endtask

	initial begin
		logic [15:0] lo_pick;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset register values. A tick with ack right after
		// reset, then a frame sitting exactly on both bounds, which must be accepted.
		push_item(1'b1, 8'h00, 1'b1);
		send_frame(RST_MIN_VALID, RST_MAX_VALID, RST_END_CHAR);
		// Acknowledge the new frame on a tick.
		push_item(1'b1, 8'hFF, 1'b1);
		// A frame closed by the start character is dropped, and that byte must not
		// open a new frame: the next frame only lines up if the parser got this right.
		send_frame(16'd1000, 16'd1000, RST_START_CHAR);
		send_frame(RST_MAX_VALID, RST_MIN_VALID, RST_END_CHAR);
		// Both channels one step outside the window: rejected, state kept.
		send_frame(RST_MIN_VALID - 16'd1, RST_MAX_VALID + 16'd1, RST_END_CHAR);

		run_traffic(250);

		// Widest window, lowest start and highest end character, zero timeout.
		program_link(8'h00, 8'hFF, 16'd0, 16'hFFFF, 16'd0);
		run_traffic(350);

		// A window of one value, reversed extremes for the characters, and a
		// timeout that can never expire.
		program_link(8'hFF, 8'h00, 16'hA55A, 16'hA55A, 16'hFFFF);
		run_traffic(300);

		// Inverted bounds: every properly closed frame is rejected.
		program_link(8'($urandom), 8'($urandom), 16'd3000, 16'd2999, 16'd5);
		run_traffic(250);

		// Random characters and window, short random timeout.
		lo_pick = 16'($urandom_range(0, 60000));
		program_link(8'($urandom), 8'($urandom), lo_pick,
			lo_pick + 16'($urandom_range(0, 5000)), 16'($urandom_range(1, 30)));
		run_traffic(550);

		// Start and end character the same.
		program_link(8'h3C, 8'h3C, 16'd0, 16'd1000, 16'd2);
		run_traffic(200);

		// Timeout edge: after a good frame on the extremes of the widest window,
		// failsafe stays low while the count equals the timeout and trips on the
		// tick that passes it.
		idle_pct     = 0;
		stall_pct    = 0;
		ack_pct      = 0;
		tick_mix_pct = 0;
		program_link(RST_START_CHAR, RST_END_CHAR, 16'd0, 16'hFFFF, 16'd3);
		send_frame(16'd0, 16'hFFFF, RST_END_CHAR);
		repeat (4) push_item(1'b1, 8'($urandom), 1'b0);

		drain_link();

		$display("Drove %0d transfers through %0d register settings, %s",
			items_sent, settings_n, "timeout edge included.");
		$display("Checked %0d results: %0d frames accepted, %0d rejected, %s",
			checked_n, accepted_n, rejected_n, "outstanding and mismatch counts follow.");
		$display("%0d mismatches, %0d missing.", mismatch_n, pending_n);
		if (mismatch_n == 0 && pending_n == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
